FILE: rtl/hdlc_rx_deframer_packet_ring_macros.svh
// Assertion macros used by the deframer top-level RTL.
`ifndef HDLC_RX_DEFRAMER_PACKET_RING_MACROS_SVH
`define HDLC_RX_DEFRAMER_PACKET_RING_MACROS_SVH

`ifndef SYNTHESIS

// Plain property checked at every clock edge outside reset.
`define HRX_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("hdlc rx assertion failed");

// Implication checked in the same cycle.
`define HRX_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hdlc rx assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define HRX_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hdlc rx assertion failed");

`else

`define HRX_ASSERT(name, clk, rst, prop)
`define HRX_ASSERT_IMPL(name, clk, rst, ante, cons)
`define HRX_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/hdlcrx_pkg.sv
package hdlcrx_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7e;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7d;
  localparam logic [7:0] ESCAPE_XOR  = 8'h20;
  localparam logic [7:0] ABORT_MASK  = 8'h7f;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    EV_STORED        = 4'd0,
    EV_CLOSED        = 4'd1,
    EV_EMPTY         = 4'd2,
    EV_ESCAPE        = 4'd3,
    EV_LINE_DROP     = 4'd4,
    EV_ABORT_DROP    = 4'd5,
    EV_OVERFLOW_DROP = 4'd6,
    EV_RELEASED      = 4'd7,
    EV_NONE          = 4'd8
  } evt_t;

  typedef struct packed {
    evt_t evt;
    logic write_valid;
  } res_ctl_t;

endpackage

FILE: rtl/hdlc_rx_deframer_packet_ring.sv
// HDLC receive deframer: strips flag/escape byte stuffing from received UART
// bytes and hands each stored byte out as an address/data pair for an
// external byte ring of BUF_DEPTH entries (at most BUF_DEPTH-1 bytes held).
// Completed frames are tracked in a ring of SLOT_COUNT packet slots, of which
// at most SLOT_COUNT-2 can be pending; a release transfer frees the oldest one
// and reports its start and length. Every input transfer gives exactly one
// result, in the cycle after it is taken, and a new transfer can be taken
// every cycle while input stall is low: all decode and pointer updates are
// combinational into the result register, and the slot end-address RAM
// has a registered, forwarded read that always holds the oldest packet's
// end. Input stall rises only while a result is held by output stall.
`include "hdlc_rx_deframer_packet_ring_macros.svh"

module hdlc_rx_deframer_packet_ring #(
  parameter int BUF_DEPTH  = 128,
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [7:0]                    rx_byte,
  input  logic                          line_error,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    event_res,
  output logic                          write_valid,
  output logic [$clog2(BUF_DEPTH)-1:0]  write_addr,
  output logic [7:0]                    write_data,
  output logic [$clog2(BUF_DEPTH)-1:0]  pkt_start,
  output logic [$clog2(BUF_DEPTH)-1:0]  pkt_length,
  output logic [$clog2(SLOT_COUNT)-1:0] pending_count
);

  import hdlcrx_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int SW = $clog2(SLOT_COUNT);

  logic          take;
  res_ctl_t      ctl;
  logic [AW-1:0] c_write_addr;
  logic [7:0]    c_write_data;
  logic [AW-1:0] c_pkt_start;
  logic [AW-1:0] c_pkt_length;
  logic [SW-1:0] c_pending;
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [AW-1:0] ram_wdata;
  logic [SW-1:0] ram_raddr;
  logic [AW-1:0] oldest_end;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  hdlcrx_frame_ctl #(
    .BUF_DEPTH  (BUF_DEPTH),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_frame_ctl (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .kind          (kind),
    .rx_byte       (rx_byte),
    .line_error    (line_error),
    .oldest_end    (oldest_end),
    .ctl           (ctl),
    .write_addr    (c_write_addr),
    .write_data    (c_write_data),
    .pkt_start     (c_pkt_start),
    .pkt_length    (c_pkt_length),
    .pending_count (c_pending),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr)
  );

  hdlcrx_slot_ram #(
    .SLOT_COUNT (SLOT_COUNT),
    .WIDTH      (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (oldest_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      event_res     <= ctl.evt;
      write_valid   <= ctl.write_valid;
      write_addr    <= c_write_addr;
      write_data    <= c_write_data;
      pkt_start     <= c_pkt_start;
      pkt_length    <= c_pkt_length;
      pending_count <= c_pending;
    end
  end

  `HRX_ASSERT_NEXT(a_take_gives_result, clk, rst, take, out_valid)
  `HRX_ASSERT_IMPL(a_write_only_stored, clk, rst, out_valid && write_valid, event_res == EV_STORED)
  `HRX_ASSERT_IMPL(a_pending_bound, clk, rst, out_valid, int'(pending_count) <= SLOT_COUNT - 2)
  `HRX_ASSERT_IMPL(a_release_no_write, clk, rst, out_valid && event_res == EV_RELEASED, !write_valid)

endmodule

FILE: rtl/hdlcrx_slot_ram.sv
// End address of each completed packet, one entry per slot.
module hdlcrx_slot_ram #(
  parameter int SLOT_COUNT = 8,
  parameter int WIDTH      = 7
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(SLOT_COUNT)-1:0] waddr,
  input  logic [WIDTH-1:0]              wdata,
  input  logic [$clog2(SLOT_COUNT)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first forwarding so a packet closed this cycle is readable next cycle
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/hdlcrx_frame_ctl.sv
// Destuffing decode and ring pointer update for one transfer.
module hdlcrx_frame_ctl #(
  parameter int BUF_DEPTH  = 128,
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          kind,
  input  logic [7:0]                    rx_byte,
  input  logic                          line_error,
  input  logic [$clog2(BUF_DEPTH)-1:0]  oldest_end,
  output hdlcrx_pkg::res_ctl_t          ctl,
  output logic [$clog2(BUF_DEPTH)-1:0]  write_addr,
  output logic [7:0]                    write_data,
  output logic [$clog2(BUF_DEPTH)-1:0]  pkt_start,
  output logic [$clog2(BUF_DEPTH)-1:0]  pkt_length,
  output logic [$clog2(SLOT_COUNT)-1:0] pending_count,
  output logic                          ram_we,
  output logic [$clog2(SLOT_COUNT)-1:0] ram_waddr,
  output logic [$clog2(BUF_DEPTH)-1:0]  ram_wdata,
  output logic [$clog2(SLOT_COUNT)-1:0] ram_raddr
);

  import hdlcrx_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int SW = $clog2(SLOT_COUNT);

  // cur_start: start of frame in progress; wr_ptr: its next write address;
  // rd_start: start of the oldest kept data
  logic [SW-1:0] write_slot, write_slot_next;
  logic [SW-1:0] read_slot, read_slot_next;
  logic [AW-1:0] cur_start, cur_start_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_start, rd_start_next;
  logic          escape_pending, escape_pending_next;

  logic [SW-1:0] ws_inc;
  logic [SW-1:0] ws_inc2;
  logic [SW-1:0] rs_inc;
  logic [AW-1:0] wr_inc;
  logic [7:0]    data_x;

  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
    return (s == SW'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    ws_inc  = slot_next(write_slot);
    ws_inc2 = slot_next(ws_inc);
    rs_inc  = slot_next(read_slot);
    wr_inc  = (wr_ptr == AW'(BUF_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    data_x  = escape_pending ? (rx_byte ^ ESCAPE_XOR) : rx_byte;
  end

  always_comb begin
    write_slot_next     = write_slot;
    read_slot_next      = read_slot;
    cur_start_next      = cur_start;
    wr_ptr_next         = wr_ptr;
    rd_start_next       = rd_start;
    escape_pending_next = escape_pending;
    ctl.evt             = EV_NONE;
    ctl.write_valid     = 1'b0;
    write_addr          = '0;
    write_data          = '0;
    pkt_start           = '0;
    pkt_length          = '0;
    ram_we              = 1'b0;
    ram_waddr           = write_slot;
    ram_wdata           = wr_ptr;

    if (take) begin
      priority if (kind == KIND_RELEASE) begin
        if (read_slot != write_slot) begin
          pkt_start      = rd_start;
          pkt_length     = oldest_end - rd_start;
          // packet wraps past the end of the byte ring
          if (oldest_end < rd_start) begin
            pkt_length = oldest_end + AW'(BUF_DEPTH) - rd_start;
          end
          read_slot_next = rs_inc;
          rd_start_next  = oldest_end;
          ctl.evt        = EV_RELEASED;
        end
      end else if (line_error) begin
        wr_ptr_next         = cur_start;
        escape_pending_next = 1'b0;
        ctl.evt             = EV_LINE_DROP;
      end else if (rx_byte == FLAG_BYTE) begin
        escape_pending_next = 1'b0;
        if (cur_start == wr_ptr) begin
          ctl.evt = EV_EMPTY;
        end else if (ws_inc2 == read_slot) begin
          wr_ptr_next = cur_start;
          ctl.evt     = EV_OVERFLOW_DROP;
        end else begin
          write_slot_next = ws_inc;
          cur_start_next  = wr_ptr;
          ram_we          = 1'b1;
          ctl.evt         = EV_CLOSED;
        end
      end else if ((rx_byte & ABORT_MASK) == ABORT_MASK) begin
        wr_ptr_next         = cur_start;
        escape_pending_next = 1'b0;
        ctl.evt             = EV_ABORT_DROP;
      end else if (rx_byte == ESCAPE_BYTE) begin
        escape_pending_next = 1'b1;
        ctl.evt             = EV_ESCAPE;
      end else begin
        escape_pending_next = 1'b0;
        if (wr_inc == rd_start) begin
          wr_ptr_next = cur_start;
          ctl.evt     = EV_OVERFLOW_DROP;
        end else begin
          ctl.write_valid = 1'b1;
          write_addr      = wr_ptr;
          write_data      = data_x;
          wr_ptr_next     = wr_inc;
          ctl.evt         = EV_STORED;
        end
      end
    end

    // RAM output always tracks the end of the packet at read_slot
    ram_raddr     = read_slot_next;
    pending_count = write_slot_next - read_slot_next;
    if (write_slot_next < read_slot_next) begin
      pending_count = write_slot_next + SW'(SLOT_COUNT) - read_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= '0;
      read_slot      <= '0;
      cur_start      <= '0;
      wr_ptr         <= '0;
      rd_start       <= '0;
      escape_pending <= 1'b0;
    end else begin
      write_slot     <= write_slot_next;
      read_slot      <= read_slot_next;
      cur_start      <= cur_start_next;
      wr_ptr         <= wr_ptr_next;
      rd_start       <= rd_start_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

FILE: test/hdlc_deframe_checker.sv
module hdlc_deframe_checker
  import hdlcrx_pkg::*;
#(
  parameter int BUF_DEPTH  = 128,
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          kind,
  input  logic [7:0]                    rx_byte,
  input  logic                          line_error,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [3:0]                    event_res,
  input  logic                          write_valid,
  input  logic [$clog2(BUF_DEPTH)-1:0]  write_addr,
  input  logic [7:0]                    write_data,
  input  logic [$clog2(BUF_DEPTH)-1:0]  pkt_start,
  input  logic [$clog2(BUF_DEPTH)-1:0]  pkt_length,
  input  logic [$clog2(SLOT_COUNT)-1:0] pending_count,
  output int                            mismatches,
  output int                            open_count
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int SW = $clog2(SLOT_COUNT);

  typedef struct packed {
    evt_t          evt;
    logic          wvalid;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] pstart;
    logic [AW-1:0] plen;
    logic [SW-1:0] pend;
  } ring_res_t;

  // packet boundary ring and destuffer state
  logic [AW-1:0] slot_start [SLOT_COUNT];
  int            wr_slot;
  int            rd_slot;
  bit            esc_pending;

  ring_res_t results_q [$];

  function automatic int slot_inc(input int s);
    return (s + 1 >= SLOT_COUNT) ? 0 : s + 1;
  endfunction

  function automatic int addr_inc(input int a);
    return (a + 1 >= BUF_DEPTH) ? 0 : a + 1;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < SLOT_COUNT; i++) slot_start[i] = '0;
    wr_slot     = 0;
    rd_slot     = 0;
    esc_pending = 1'b0;
  endfunction

  // rewind the write pointer to the start of the frame in progress
  function automatic void abandon_frame();
    slot_start[slot_inc(wr_slot)] = slot_start[wr_slot];
    esc_pending = 1'b0;
  endfunction

  function automatic ring_res_t deframe_step(input logic k, input logic [7:0] b,
                                             input logic e);
    ring_res_t  r;
    int         nxt;
    int         nr;
    int         wp;
    logic [7:0] d;
    r     = '0;
    r.evt = EV_NONE;
    nxt   = slot_inc(wr_slot);
    d     = b;
    if (k == KIND_RELEASE) begin
      if (rd_slot != wr_slot) begin
        nr       = slot_inc(rd_slot);
        r.pstart = slot_start[rd_slot];
        r.plen   = AW'((int'(slot_start[nr]) + BUF_DEPTH - int'(slot_start[rd_slot]))
                       % BUF_DEPTH);
        rd_slot  = nr;
        r.evt    = EV_RELEASED;
      end
    end else if (e) begin
      abandon_frame();
      r.evt = EV_LINE_DROP;
    end else if (d == FLAG_BYTE) begin
      esc_pending = 1'b0;
      if (slot_start[wr_slot] == slot_start[nxt]) begin
        r.evt = EV_EMPTY;
      end else if (slot_inc(nxt) == rd_slot) begin
        // no free slot for another packet
        abandon_frame();
        r.evt = EV_OVERFLOW_DROP;
      end else begin
        wr_slot = nxt;
        slot_start[slot_inc(nxt)] = slot_start[nxt];
        r.evt = EV_CLOSED;
      end
    end else if ((d & ABORT_MASK) == ABORT_MASK) begin
      abandon_frame();
      r.evt = EV_ABORT_DROP;
    end else if (d == ESCAPE_BYTE) begin
      esc_pending = 1'b1;
      r.evt = EV_ESCAPE;
    end else begin
      wp = slot_start[nxt];
      if (esc_pending) begin
        esc_pending = 1'b0;
        d = d ^ ESCAPE_XOR;
      end
      if (addr_inc(wp) == int'(slot_start[rd_slot])) begin
        abandon_frame();
        r.evt = EV_OVERFLOW_DROP;
      end else begin
        r.wvalid        = 1'b1;
        r.waddr         = AW'(wp);
        r.wdata         = d;
        slot_start[nxt] = AW'(addr_inc(wp));
        r.evt           = EV_STORED;
      end
    end
    r.pend = SW'((wr_slot + SLOT_COUNT - rd_slot) % SLOT_COUNT);
    return r;
  endfunction

  always @(posedge clk) begin
    ring_res_t got;
    ring_res_t want;
    if (rst) begin
      clear_ring();
      results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.evt    = evt_t'(event_res);
        got.wvalid = write_valid;
        got.waddr  = write_addr;
        got.wdata  = write_data;
        got.pstart = pkt_start;
        got.plen   = pkt_length;
        got.pend   = pending_count;
        if (results_q.size() == 0) begin
          if (mismatches < 10)
            $display("deframer result with no transfer pending: ev=%0d", event_res);
          mismatches++;
        end else begin
          want = results_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $write("deframer mismatch: expected ev=%0d wv=%0b addr=%0d data=%02h ",
                     want.evt, want.wvalid, want.waddr, want.wdata);
              $write("start=%0d len=%0d pend=%0d, ", want.pstart, want.plen, want.pend);
              $write("got ev=%0d wv=%0b addr=%0d data=%02h ",
                     event_res, write_valid, write_addr, write_data);
              $display("start=%0d len=%0d pend=%0d", pkt_start, pkt_length, pending_count);
            end
            mismatches++;
          end
        end
      end
      // a result never comes out in the cycle its transfer is taken
      if (in_valid && !in_stall)
        results_q.push_back(deframe_step(kind, rx_byte, line_error));
    end
    open_count = results_q.size();
  end

endmodule

FILE: test/testbench.sv
module testbench;
  import hdlcrx_pkg::*;

  localparam int BUF_DEPTH   = 128;
  localparam int SLOT_COUNT  = 8;
  localparam int AW          = $clog2(BUF_DEPTH);
  localparam int SW          = $clog2(SLOT_COUNT);
  localparam int HOLD_CYCLES = 50;

  logic          clk        = 1'b0;
  logic          rst        = 1'b1;
  logic          in_valid   = 1'b0;
  logic          in_stall;
  logic          kind       = KIND_BYTE;
  logic [7:0]    rx_byte    = '0;
  logic          line_error = 1'b0;
  logic          out_valid;
  logic          out_stall  = 1'b0;
  logic [3:0]    event_res;
  logic          write_valid;
  logic [AW-1:0] write_addr;
  logic [7:0]    write_data;
  logic [AW-1:0] pkt_start;
  logic [AW-1:0] pkt_length;
  logic [SW-1:0] pending_count;

  int mismatches;
  int open_count;
  int items_sent = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;

  hdlc_rx_deframer_packet_ring #(
    .BUF_DEPTH (BUF_DEPTH),
    .SLOT_COUNT(SLOT_COUNT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .rx_byte      (rx_byte),
    .line_error   (line_error),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .write_valid  (write_valid),
    .write_addr   (write_addr),
    .write_data   (write_data),
    .pkt_start    (pkt_start),
    .pkt_length   (pkt_length),
    .pending_count(pending_count)
  );

  hdlc_deframe_checker #(
    .BUF_DEPTH (BUF_DEPTH),
    .SLOT_COUNT(SLOT_COUNT)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .rx_byte      (rx_byte),
    .line_error   (line_error),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .write_valid  (write_valid),
    .write_addr   (write_addr),
    .write_data   (write_data),
    .pkt_start    (pkt_start),
    .pkt_length   (pkt_length),
    .pending_count(pending_count),
    .mismatches   (mismatches),
    .open_count   (open_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

  // one transfer, then maybe a short gap with valid low
  task automatic send_item(input logic k, input logic [7:0] b, input logic e);
    in_valid   <= 1'b1;
    kind       <= k;
    rx_byte    <= b;
    line_error <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(KIND_BYTE, b, 1'b0);
  endtask

  task automatic send_release();
    send_item(KIND_RELEASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (open_count == 0);
    @(posedge clk);
  endtask

  task automatic inject_noise();
    case ($urandom_range(0, 4))
      0: send_item(KIND_BYTE, 8'($urandom_range(0, 255)), 1'b1);
      1: send_byte($urandom_range(0, 1) ? (ABORT_MASK | 8'h80) : ABORT_MASK);
      2: send_byte(8'($urandom_range(0, 255)));
      3: begin
        send_byte(ESCAPE_BYTE);
        send_byte(ESCAPE_BYTE);
      end
      default: begin
        send_byte(ESCAPE_BYTE);
        send_byte(FLAG_BYTE);
      end
    endcase
  endtask

  // well-formed stuffed frame closed by a flag, optionally with noise mixed in
  task automatic send_frame(input int len, input bit noisy);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) inject_noise();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: b = FLAG_BYTE;
          1: b = ESCAPE_BYTE;
          2: b = ABORT_MASK;
          default: b = ABORT_MASK | 8'h80;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      if (b == FLAG_BYTE || b == ESCAPE_BYTE || (b & ABORT_MASK) == ABORT_MASK) begin
        send_byte(ESCAPE_BYTE);
        send_byte(b ^ ESCAPE_XOR);
      end else begin
        send_byte(b);
      end
    end
    send_byte(FLAG_BYTE);
  endtask

  task automatic run_random(input int n);
    int stop;
    int rel_pct;
    int r;
    stop    = items_sent + n;
    rel_pct = 20;
    while (items_sent < stop) begin
      // release rate drifts so both rings fill up and drain
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 2))
          0: rel_pct = 5;
          1: rel_pct = 25;
          default: rel_pct = 50;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < rel_pct)
        send_release();
      else if (r < 96)
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(20, 70)
                                               : $urandom_range(1, 10),
                   $urandom_range(0, 3) == 0);
      else if (r < 98)
        send_byte(FLAG_BYTE);
      else
        inject_noise();
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_RELEASE, ABORT_MASK | 8'h80, 1'b1);   // nothing pending
    send_byte(FLAG_BYTE);                                // empty frame
    send_byte(8'h00);
    send_byte(ESCAPE_BYTE);
    send_byte(FLAG_BYTE ^ ESCAPE_XOR);
    send_byte(FLAG_BYTE);
    send_byte(ESCAPE_BYTE);                              // double escape
    send_byte(ESCAPE_BYTE);
    send_byte(ESCAPE_BYTE ^ ESCAPE_XOR);
    send_byte(8'h80);
    send_byte(FLAG_BYTE);
    send_byte(8'hfe);
    send_byte(ABORT_MASK);
    send_byte(8'h01);
    send_item(KIND_BYTE, FLAG_BYTE, 1'b1);               // line error wins over flag
    send_byte(ESCAPE_BYTE);
    send_byte(FLAG_BYTE);                                // flag clears escape
    send_byte(8'h55);
    send_byte(ESCAPE_BYTE);
    send_byte(ABORT_MASK | 8'h80);
    send_byte(ESCAPE_BYTE);
    send_item(KIND_BYTE, 8'h12, 1'b1);
    send_release();
    send_release();
    send_release();
    send_item(KIND_RELEASE, 8'h00, 1'b0);
    drain_results();

    run_random(400);
    hold_req = 1'b1;
    run_random(60);
    drain_results();
    run_random(300);
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;
    run_random(300);
    calm = 1'b1;
    run_random(200);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (open_count == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && open_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
